/* rtl/sha_pkg.sv */
`default_nettype none
package sha_pkg;

  localparam logic [1:0] FUNC_ABSORB = 2'd0;
  localparam logic [1:0] FUNC_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  typedef logic [31:0] word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       absorb;    // write message_byte into the buffer, bump counts
    logic       pad_init;  // start padding: write 0x80 at fill
    logic       pad_zero;  // write zero at pad position
    logic       pad_len;   // write length byte at pad position
    logic       pad_step;  // advance pad position
    logic       load_w;    // reset round index, copy chain to vars
    logic       round;     // run one round
    logic       fold;      // add vars into chain
    logic       restart;   // return to initial state
    logic       out_shift; // rotate chain for output
  } sha_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       fill_wrap;  // buffer holds 63 bytes; next absorb fills it
    logic [5:0] pad_pos;
    logic [5:0] round_idx;
  } sha_sts_t;

  function automatic word_t rotr(input word_t x, input int s);
    rotr = (x >> s) | (x << (32 - s));
  endfunction

  function automatic word_t init_word(input logic [2:0] i);
    case (i)
      3'd0: init_word = 32'h6a09e667;
      3'd1: init_word = 32'hbb67ae85;
      3'd2: init_word = 32'h3c6ef372;
      3'd3: init_word = 32'ha54ff53a;
      3'd4: init_word = 32'h510e527f;
      3'd5: init_word = 32'h9b05688c;
      3'd6: init_word = 32'h1f83d9ab;
      default: init_word = 32'h5be0cd19;
    endcase
  endfunction

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage
`default_nettype wire

/* rtl/sha_if.sv */
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] message_byte;
  modport source (output valid, func, message_byte, input ready);
  modport sink (input valid, func, message_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* rtl/sha_datapath.sv */
`default_nettype none
module sha_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sha_pkg::sha_cmd_t cmd,
  input  wire logic [7:0]       in_byte,
  output sha_pkg::sha_sts_t     sts,
  output sha_pkg::word_t        out_word
);

  // block buffer: 64 bytes held as 16 words in a shift window
  sha_pkg::word_t w_r [16];
  sha_pkg::word_t v_r [8];
  sha_pkg::word_t chain_r [8];
  logic [5:0]  fill_r;
  logic [60:0] total_r;
  logic [5:0]  pad_r;
  logic [5:0]  rnd_r;

  sha_pkg::word_t big0, big1, ch, maj, t1, t2, s0, s1, w_new;
  logic [63:0] bits;
  logic [7:0]  len_byte;
  logic [7:0]  wr_byte;
  logic [5:0]  wr_pos;
  logic        wr_en;
  logic [2:0]  len_sel;

  always_comb begin
    big1 = sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11) ^ sha_pkg::rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + big1 + ch + sha_pkg::ROUND_K[rnd_r] + w_r[0];
    big0 = sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13) ^ sha_pkg::rotr(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = big0 + maj;
    s0 = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
  end

  assign bits = {total_r, 3'b000};
  assign len_sel = pad_r[2:0];
  always_comb begin
    len_byte = bits[63 - 8 * len_sel -: 8];
  end

  always_comb begin
    wr_en = 1'b0;
    wr_byte = 8'h00;
    wr_pos = pad_r;
    if (cmd.absorb) begin
      wr_en = 1'b1;
      wr_byte = in_byte;
      wr_pos = fill_r;
    end else if (cmd.pad_init) begin
      wr_en = 1'b1;
      wr_byte = sha_pkg::PAD_BYTE;
      wr_pos = fill_r;
    end else if (cmd.pad_zero) begin
      wr_en = 1'b1;
    end else if (cmd.pad_len) begin
      wr_en = 1'b1;
      wr_byte = len_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      fill_r <= '0;
      total_r <= '0;
      pad_r <= '0;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::init_word(3'(i));
    end else begin
      if (cmd.absorb) begin
        fill_r <= fill_r + 6'd1;
        total_r <= total_r + 61'd1;
      end
      if (cmd.pad_init) pad_r <= fill_r + 6'd1;
      else if (cmd.pad_step) pad_r <= pad_r + 6'd1;
      if (cmd.load_w) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
      end else if (cmd.out_shift) begin
        for (int i = 0; i < 7; i++) chain_r[i] <= chain_r[i + 1];
        chain_r[7] <= chain_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) w_r[wr_pos[5:2]][8 * (3 - wr_pos[1:0]) +: 8] <= wr_byte;
    if (cmd.load_w) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_new;
    end
  end

  assign sts.fill_wrap = (fill_r == 6'd63);
  assign sts.pad_pos = pad_r;
  assign sts.round_idx = rnd_r;
  assign out_word = chain_r[0];

endmodule
`default_nettype wire

/* rtl/sha_ctrl.sv */
`default_nettype none
module sha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_func,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_index,
  output sha_pkg::sha_cmd_t      cmd,
  input  wire sha_pkg::sha_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1; // pad bytes up to end of block
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;         // finish requested, padding not started yet
  logic       padding_r, padding_nxt; // padding blocks in progress
  logic       len_r, len_nxt;         // length bytes present in current block
  logic [2:0] idx_r, idx_nxt;
  logic       take;

  assign in_ready = (state_r == S_IDLE) && !fin_r;
  assign take = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_index = idx_r;

  always_comb begin
    state_nxt = state_r;
    fin_nxt = fin_r;
    padding_nxt = padding_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_func)
            sha_pkg::FUNC_ABSORB: begin
              cmd.absorb = 1'b1;
              if (sts.fill_wrap) state_nxt = S_LOAD;
            end
            sha_pkg::FUNC_ABSORB_FINISH: begin
              cmd.absorb = 1'b1;
              fin_nxt = 1'b1;
              // padding starts on next idle pass
              if (sts.fill_wrap) state_nxt = S_LOAD;
            end
            sha_pkg::FUNC_FINISH: begin
              cmd.pad_init = 1'b1;
              padding_nxt = 1'b1;
              len_nxt = 1'b0;
              state_nxt = S_PAD;
            end
            default: ;
          endcase
        end else if (fin_r) begin
          // deferred start of padding after a final absorb
          cmd.pad_init = 1'b1;
          fin_nxt = 1'b0;
          padding_nxt = 1'b1;
          len_nxt = 1'b0;
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        // pad_pos walks up to 63; zero on entry without length means 0x80
        // took the last byte and the block is already full
        if (sts.pad_pos == 6'd0 && !len_r) begin
          state_nxt = S_LOAD;
        end else begin
          // passing offset 56 marks the block that carries the length
          if (sts.pad_pos >= sha_pkg::LEN_OFFSET
              && (len_r || sts.pad_pos == sha_pkg::LEN_OFFSET)) begin
            cmd.pad_len = 1'b1;
            len_nxt = 1'b1;
          end else begin
            cmd.pad_zero = 1'b1;
          end
          cmd.pad_step = 1'b1;
          if (sts.pad_pos == 6'd63) state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_w = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_idx == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (padding_r && len_r) begin
          idx_nxt = '0;
          state_nxt = S_OUT;
        end else if (padding_r) begin
          // spill: next block is zeros plus length, pad_pos is back at 0
          len_nxt = 1'b1;
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.out_shift = 1'b1;
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.restart = 1'b1;
            fin_nxt = 1'b0;
            padding_nxt = 1'b0;
            len_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r <= 1'b0;
      padding_r <= 1'b0;
      len_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r <= fin_nxt;
      padding_r <= padding_nxt;
      len_r <= len_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/sha256_message_hasher.sv */
`default_nettype none
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | func[1:0], message_byte[7:0]
// out     | out | out_valid/out_ready| digest_word[31:0], word_index[2:0], last_word
//
// Each absorbed byte is written into the block buffer; the 64th byte of a block
// adds a compression (load, 64 rounds on the one round unit, fold).
// Finish pads byte by byte (after a final absorb, padding waits for an idle
// pass) and runs one or two compressions, then offers
// eight digest words, one per out handshake.
// rst_n is synchronous; in_ready is low while finishing, padding, compressing or
// delivering the digest.
module sha256_message_hasher (
  input wire logic   clk,
  input wire logic   rst_n,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  sha_pkg::sha_cmd_t cmd;
  sha_pkg::sha_sts_t sts;
  sha_pkg::word_t    word;
  logic [2:0]        idx;

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_index (idx),
    .cmd       (cmd),
    .sts       (sts)
  );

  sha_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_byte  (in_ch.message_byte),
    .sts      (sts),
    .out_word (word)
  );

  assign out_ch.digest_word = word;
  assign out_ch.word_index = idx;
  assign out_ch.last_word = (idx == 3'd7);

endmodule
`default_nettype wire

/* rtl/sha_checker.sv */
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input open during digest");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("last_word");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("index step");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> word_index == 3'd0) else $error("start index");
endmodule

bind sha256_message_hasher sha_checker u_chk (
  .clk (clk), .rst_n (rst_n),
  .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .word_index (out_ch.word_index), .last_word (out_ch.last_word)
);
`default_nettype wire

/* verif/sha256_hasher_checker.sv */
`timescale 1ns / 1ps
module sha256_hasher_checker (
  input  logic clk,
  input  logic rst_n,
  sha_in_if    in_ch,
  sha_out_if   out_ch,
  output int   fail_count,
  output int   words_pending
);

  typedef struct packed {
    sha_pkg::word_t digest_word;
    logic [2:0]     word_index;
    logic           last_word;
  } digest_entry_t;

  digest_entry_t digest_q[$];

  sha_pkg::word_t chain_h [8];
  logic [7:0]     msg_block [64];
  logic [5:0]     block_fill;
  logic [60:0]    msg_bytes;

  assign words_pending = digest_q.size();

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = sha_pkg::init_word(i[2:0]);
    block_fill = '0;
    msg_bytes  = '0;
  endfunction

  function automatic sha_pkg::word_t ror(sha_pkg::word_t x, int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic void compress_block();
    sha_pkg::word_t w [64];
    sha_pkg::word_t v [8];
    sha_pkg::word_t t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += v[i];
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill = block_fill + 6'd1;
    msg_bytes  = msg_bytes + 61'd1;
    if (block_fill == 0) compress_block();
  endfunction

  // pad, run the last one or two compressions, queue the eight digest words
  function automatic void finish_message();
    logic [63:0] bit_len;
    int          pos;
    bit_len = {msg_bytes, 3'b000};
    pos = block_fill;
    msg_block[pos] = sha_pkg::PAD_BYTE;
    pos++;
    if (pos > sha_pkg::LEN_OFFSET) begin
      while (pos < 64) begin msg_block[pos] = 8'h00; pos++; end
      compress_block();
      pos = 0;
    end
    while (pos < sha_pkg::LEN_OFFSET) begin msg_block[pos] = 8'h00; pos++; end
    for (int i = 0; i < 8; i++) msg_block[56 + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++)
      digest_q.push_back('{chain_h[i], i[2:0], i == 7});
    restart_hash();
  endfunction

  initial begin
    fail_count = 0;
    restart_hash();
  end

  always @(posedge clk) begin
    digest_entry_t exp_w;
    if (!rst_n) begin
      restart_hash();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.func)
          sha_pkg::FUNC_ABSORB: absorb_byte(in_ch.message_byte);
          sha_pkg::FUNC_ABSORB_FINISH: begin
            absorb_byte(in_ch.message_byte);
            finish_message();
          end
          sha_pkg::FUNC_FINISH: finish_message();
          default: ;  // unused code, ignored
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_ch.digest_word);
          fail_count++;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_ch.digest_word !== exp_w.digest_word) begin
            $error("digest_word expected %h actual %h", exp_w.digest_word, out_ch.digest_word);
            fail_count++;
          end
          if (out_ch.word_index !== exp_w.word_index) begin
            $error("word_index expected %0d actual %0d", exp_w.word_index, out_ch.word_index);
            fail_count++;
          end
          if (out_ch.last_word !== exp_w.last_word) begin
            $error("last_word expected %0d actual %0d", exp_w.last_word, out_ch.last_word);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* verif/tb_sha256_message_hasher.sv */
`timescale 1ns / 1ps
module tb_sha256_message_hasher;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  int fail_count;
  int words_pending;

  // shared knobs for both sides
  bit quiet = 1'b0;       // no idling at all while set
  bit hold_req = 1'b0;    // ask receiver for one long hold-off
  int word_count = 0;     // words accepted at the input

  always #10 clk = ~clk;

  sha256_message_hasher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha256_hasher_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.func         = sha_pkg::FUNC_ABSORB;
    in_ch.message_byte = 8'h00;
    out_ch.ready       = 1'b0;
  end

  // Receiver: random ~15% stalls, plus one long hold-off on request so the
  // digest is held in delivery and in_ready stays low while the sender keeps offering.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // one word on the input channel; valid stays high across back-to-back words
  task automatic send_word(logic [1:0] f, logic [7:0] b);
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.message_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    word_count++;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // whole message: len bytes, then finish either on the last byte or alone
  task automatic send_message(int len, bit finish_on_byte, bit zeros_only);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = zeros_only ? 8'h00 : 8'($urandom);
      if (!zeros_only && $urandom_range(0, 99) < 4)
        send_word(FUNC_UNUSED, 8'($urandom));   // noise, must not disturb
      if (i == len - 1 && finish_on_byte) send_word(sha_pkg::FUNC_ABSORB_FINISH, b);
      else                                send_word(sha_pkg::FUNC_ABSORB, b);
    end
    if (len == 0 || !finish_on_byte) send_word(sha_pkg::FUNC_FINISH, 8'($urandom));
  endtask

  initial begin
    int len;
    int msg_num;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, unused code alone, single byte extremes
    send_word(FUNC_UNUSED, 8'hff);
    send_word(sha_pkg::FUNC_FINISH, 8'h5a);          // digest of the empty message
    send_word(sha_pkg::FUNC_ABSORB_FINISH, 8'hff);
    send_word(sha_pkg::FUNC_ABSORB_FINISH, 8'h00);
    send_message(3, 1'b0, 1'b1);           // zeros, separate finish
    send_word(sha_pkg::FUNC_ABSORB, 8'h80);
    send_word(FUNC_UNUSED, 8'h00);
    send_word(sha_pkg::FUNC_ABSORB_FINISH, 8'h7f);

    // random messages; lengths lean on the padding boundaries
    msg_num = 0;
    while (word_count < 140 || msg_num < 6) begin
      case ($urandom_range(0, 9))
        6:       len = 55;                    // pad and length in one block
        7:       len = 56;                    // pad spills into a second block
        8:       len = $urandom_range(63, 64); // block filled by 0x80, or full at finish
        9:       len = $urandom_range(65, 80);
        default: len = $urandom_range(0, 8);
      endcase
      quiet = (msg_num == 1);
      send_message(len, $urandom_range(0, 1), 1'b0);
      // digest is still ahead, so the next message backs up behind it
      if (msg_num == 3) hold_req = 1'b1;
      if (msg_num == 5) begin
        // sender pause until the whole digest is out
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
      end
      msg_num++;
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_message_hasher.sv
rtl/sha_checker.sv
verif/sha256_hasher_checker.sv
verif/tb_sha256_message_hasher.sv
